// ===== rtl/core/ka_pkg.sv =====
// ----------------------------------------------------------------------------
// ka_pkg: shared types and constants of the keepalive supervisor
// Event and mode codes, configuration register map and the result record
// passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package ka_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int TABLE_DEPTH_DEF = 8;
  localparam int TAG_BITS_DEF    = 16;
  localparam int TIME_BITS_DEF   = 48;

  // Fixed field widths.
  localparam int MODE_BITS      = 2;
  localparam int RTAG_BITS      = 16;
  localparam int EV_BITS        = 4;
  localparam int EV_TAG_BITS    = 16;
  localparam int COUNT_BITS     = 16;
  localparam int INTERVAL_BITS  = 32;
  localparam int LIMIT_BITS     = 34;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;

  // Long interval used when the register holds zero, and the stretch factor
  // of the timeout for long requests.
  localparam logic [INTERVAL_BITS-1:0] LONG_DEFAULT_MS     = 32'd120000;
  localparam int                       LONG_TIMEOUT_FACTOR = 2;

  // Register reset values.
  localparam logic                       SEND_ENABLE_RST = 1'b1;
  localparam logic [INTERVAL_BITS-1:0]   IDLE_RST        = 32'd30000;
  localparam logic [INTERVAL_BITS-1:0]   LONG_RST        = 32'd120000;
  localparam logic [INTERVAL_BITS-1:0]   TIMEOUT_RST     = 32'd30000;
  localparam logic [COUNT_BITS-1:0]      MAX_TIMEOUT_RST = 16'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SEND_ENABLE  = 3'd0,
    CFG_IDLE_MS      = 3'd1,
    CFG_LONG_MS      = 3'd2,
    CFG_TIMEOUT_MS   = 3'd3,
    CFG_MAX_TIMEOUTS = 3'd4
  } cfg_index_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_BEAT     = 2'd0,
    MODE_CHECK    = 2'd1,
    MODE_RESPONSE = 2'd2
  } mode_t;

  typedef enum logic [EV_BITS-1:0] {
    EV_NONE       = 4'd0,
    EV_SHORT_SENT = 4'd1,
    EV_LONG_SENT  = 4'd2,
    EV_TIMEOUT    = 4'd3,
    EV_BROKEN     = 4'd4,
    EV_FAILED     = 4'd5,
    EV_SUCCESS    = 4'd6,
    EV_DROPPED    = 4'd7,
    EV_UNMATCHED  = 4'd8
  } event_t;

  typedef struct packed {
    logic                         send_enable;
    logic [INTERVAL_BITS-1:0]     idle_interval_ms;
    logic [INTERVAL_BITS-1:0]     long_interval_ms;
    logic [INTERVAL_BITS-1:0]     timeout_ms;
    logic [COUNT_BITS-1:0]        max_timeouts;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    event_t                 code;
    logic [EV_TAG_BITS-1:0] tag;
    logic                   last;
  } emit_t;

endpackage

// ===== rtl/core/ka_ram.sv =====
// ----------------------------------------------------------------------------
// ka_ram: generic single-port-write, single-port-read memory
// One write and one read a cycle; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module ka_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ka_outreg.sv =====
// ----------------------------------------------------------------------------
// ka_outreg: result output register
// Holds one result on the master stream so that the sequencer can carry on
// with the next item while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module ka_outreg (
  input  logic                            clk,
  input  logic                            rst,
  input  ka_pkg::emit_t                   emit,
  output logic                            emit_ready,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ka_pkg::EV_TAG_BITS-1:0]  m_tdata,
  output logic [ka_pkg::EV_BITS-1:0]      m_tuser,
  output logic                            m_tlast
);

  // The register is free when empty or when its content leaves this cycle.
  assign emit_ready = !m_tvalid || m_tready;

  // Load a new result or drain the present one.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_ready) begin
      m_tvalid <= emit.valid;
    end
    if (emit_ready && emit.valid) begin
      m_tdata <= emit.tag;
      m_tuser <= emit.code;
      m_tlast <= emit.last;
    end
  end

endmodule

// ===== rtl/core/ka_seq.sv =====
// ----------------------------------------------------------------------------
// ka_seq: keepalive sequencer
// Walks the request tables held in the entry memory one entry at a time:
// free-slot search for sends, age checks for timeout ticks and tag lookup
// for responses. Valid bits, counters and the last success time live here.
// ----------------------------------------------------------------------------
module ka_seq #(
  parameter int TABLE_DEPTH = ka_pkg::TABLE_DEPTH_DEF,
  parameter int TAG_BITS    = ka_pkg::TAG_BITS_DEF,
  parameter int TIME_BITS   = ka_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ka_pkg::cfg_t                        cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ka_pkg::MODE_BITS-1:0]        in_mode,
  input  logic [TIME_BITS-1:0]                in_now,
  input  logic [TIME_BITS-1:0]                in_active,
  input  logic [ka_pkg::RTAG_BITS-1:0]        in_rtag,
  input  logic                                in_failed,
  output logic                                ram_wr_en,
  output logic [$clog2(2*TABLE_DEPTH)-1:0]    ram_wr_addr,
  output logic [TIME_BITS+TAG_BITS-1:0]       ram_wr_data,
  output logic                                ram_rd_en,
  output logic [$clog2(2*TABLE_DEPTH)-1:0]    ram_rd_addr,
  input  logic [TIME_BITS+TAG_BITS-1:0]       ram_rd_data,
  output ka_pkg::emit_t                       emit,
  input  logic                                emit_ready
);

  localparam int NUM_ENTRIES = 2 * TABLE_DEPTH;
  localparam int AW          = $clog2(NUM_ENTRIES);
  localparam int CW          = TIME_BITS + 2;
  localparam int TW          = (TAG_BITS > ka_pkg::RTAG_BITS) ? TAG_BITS : ka_pkg::RTAG_BITS;
  localparam logic [AW-1:0] LAST_POS   = AW'(NUM_ENTRIES - 1);
  localparam logic [AW-1:0] SHORT_LAST = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] LONG_FIRST = AW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_FREE,
    S_SEND,
    S_ISSUE,
    S_EVAL,
    S_BROKEN,
    S_MISS,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [ka_pkg::MODE_BITS-1:0]    mode;
  logic [TIME_BITS-1:0]            now;
  logic [TIME_BITS-1:0]            active;
  logic [ka_pkg::RTAG_BITS-1:0]    rtag;
  logic                            failed;
  logic                            sel_long;
  logic [AW-1:0]                   pos;
  logic [NUM_ENTRIES-1:0]          valid;
  logic [TAG_BITS-1:0]             next_tag;
  logic [ka_pkg::COUNT_BITS-1:0]   failure_count;
  logic [TIME_BITS-1:0]            last_success;
  logic                            pend_valid;
  ka_pkg::event_t                  pend_code;
  logic [ka_pkg::EV_TAG_BITS-1:0]  pend_tag;

  logic [TAG_BITS-1:0]             rd_tag;
  logic [TIME_BITS-1:0]            rd_sent;
  logic [ka_pkg::INTERVAL_BITS-1:0] long_lim;
  logic [ka_pkg::LIMIT_BITS-1:0]   scan_lim;
  logic                            idle_old;
  logic                            succ_old;
  logic                            expired;
  logic                            tag_hit;
  logic [ka_pkg::COUNT_BITS-1:0]   count_inc;
  logic [AW-1:0]                   free_end;
  logic                            is_check;
  logic                            is_resp;
  logic                            at_end;
  state_t                          end_state;
  logic                            put_req;
  ka_pkg::event_t                  put_code;
  logic [ka_pkg::EV_TAG_BITS-1:0]  put_tag;
  logic                            can_put;
  logic                            put_go;

  // Age test: the age of a later time never exceeds any limit.
  function automatic logic older(input logic [TIME_BITS-1:0] t_now,
                                 input logic [TIME_BITS-1:0] t_then,
                                 input logic [ka_pkg::LIMIT_BITS-1:0] limit);
    logic [CW-1:0] diff;
    diff = CW'(t_now) - CW'(t_then);
    return !diff[CW-1] && (diff > CW'(limit));
  endfunction

  // Tag as carried on the result stream.
  function automatic logic [ka_pkg::EV_TAG_BITS-1:0] ev_tag(input logic [TAG_BITS-1:0] t);
    logic [TW-1:0] wide;
    wide = TW'(t);
    return wide[ka_pkg::EV_TAG_BITS-1:0];
  endfunction

  // Entry layout in memory: send time above the tag.
  assign rd_tag  = ram_rd_data[TAG_BITS-1:0];
  assign rd_sent = ram_rd_data[TIME_BITS+TAG_BITS-1:TAG_BITS];

  // Interval and limit selection, and the compares of the current step.
  always_comb begin
    long_lim  = (cfg.long_interval_ms == '0) ? ka_pkg::LONG_DEFAULT_MS : cfg.long_interval_ms;
    scan_lim  = (pos >= LONG_FIRST)
                ? ka_pkg::LIMIT_BITS'(cfg.timeout_ms)
                  * ka_pkg::LIMIT_BITS'(ka_pkg::LONG_TIMEOUT_FACTOR)
                : ka_pkg::LIMIT_BITS'(cfg.timeout_ms);
    idle_old  = older(now, active, ka_pkg::LIMIT_BITS'(cfg.idle_interval_ms));
    succ_old  = older(now, last_success, ka_pkg::LIMIT_BITS'(long_lim));
    expired   = older(now, rd_sent, scan_lim);
    tag_hit   = (TW'(rd_tag) == TW'(rtag));
    count_inc = (failure_count == '1) ? failure_count : failure_count + 1'b1;
    free_end  = sel_long ? LAST_POS : SHORT_LAST;
    is_check  = (mode == ka_pkg::MODE_CHECK);
    is_resp   = (mode == ka_pkg::MODE_RESPONSE);
    at_end    = (pos == LAST_POS);
    end_state = is_resp ? S_MISS : S_FINISH;
  end

  // New result wanted by the current step.
  always_comb begin
    put_req  = 1'b0;
    put_code = ka_pkg::EV_NONE;
    put_tag  = '0;
    unique case (state)
      S_FREE: begin
        if (valid[pos] && (pos == free_end)) begin
          put_req  = 1'b1;
          put_code = ka_pkg::EV_DROPPED;
          put_tag  = ev_tag(next_tag);
        end
      end
      S_SEND: begin
        put_req  = 1'b1;
        put_code = sel_long ? ka_pkg::EV_LONG_SENT : ka_pkg::EV_SHORT_SENT;
        put_tag  = ev_tag(next_tag);
      end
      S_EVAL: begin
        if (is_check && expired) begin
          put_req  = 1'b1;
          put_code = ka_pkg::EV_TIMEOUT;
          put_tag  = ev_tag(rd_tag);
        end else if (is_resp && tag_hit) begin
          put_req  = 1'b1;
          put_code = failed ? ka_pkg::EV_FAILED : ka_pkg::EV_SUCCESS;
          put_tag  = rtag;
        end
      end
      S_BROKEN: begin
        put_req  = 1'b1;
        put_code = ka_pkg::EV_BROKEN;
        put_tag  = ev_tag(rd_tag);
      end
      S_MISS: begin
        put_req  = 1'b1;
        put_code = ka_pkg::EV_UNMATCHED;
        put_tag  = rtag;
      end
      default: begin
        put_req = 1'b0;
      end
    endcase
  end

  // A result is held back one step so that the final one can carry last.
  assign can_put = !pend_valid || emit_ready;
  assign put_go  = put_req && can_put;

  always_comb begin
    emit.valid = (put_req && pend_valid) || (state == S_FINISH);
    emit.last  = (state == S_FINISH);
    emit.code  = pend_valid ? pend_code : ka_pkg::EV_NONE;
    emit.tag   = pend_valid ? pend_tag : '0;
  end

  // Memory accesses: reads during scans, one write when a request is sent.
  assign in_ready    = (state == S_IDLE);
  assign ram_rd_en   = (state == S_ISSUE) && valid[pos];
  assign ram_rd_addr = pos;
  assign ram_wr_en   = (state == S_SEND) && can_put;
  assign ram_wr_addr = pos;
  assign ram_wr_data = {now, next_tag};

  // Sequencer state, table valid bits and supervisor counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pos           <= '0;
      sel_long      <= 1'b0;
      valid         <= '0;
      next_tag      <= '0;
      failure_count <= '0;
      last_success  <= '0;
      pend_valid    <= 1'b0;
    end else begin
      if (put_go) begin
        pend_valid <= 1'b1;
        pend_code  <= put_code;
        pend_tag   <= put_tag;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode   <= in_mode;
            now    <= in_now;
            active <= in_active;
            rtag   <= in_rtag;
            failed <= in_failed;
            pos    <= '0;
            case (in_mode)
              ka_pkg::MODE_BEAT:     state <= cfg.send_enable ? S_DECIDE : S_FINISH;
              ka_pkg::MODE_CHECK:    state <= S_ISSUE;
              ka_pkg::MODE_RESPONSE: state <= S_ISSUE;
              default:               state <= S_FINISH;
            endcase
          end
        end
        S_DECIDE: begin
          priority if (idle_old) begin
            sel_long <= 1'b0;
            pos      <= '0;
            state    <= S_FREE;
          end else if (succ_old) begin
            sel_long <= 1'b1;
            pos      <= LONG_FIRST;
            state    <= S_FREE;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FREE: begin
          priority if (!valid[pos]) begin
            state <= S_SEND;
          end else if (pos == free_end) begin
            if (can_put) begin
              state <= S_FINISH;
            end
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_SEND: begin
          if (can_put) begin
            valid[pos] <= 1'b1;
            next_tag   <= next_tag + 1'b1;
            state      <= S_FINISH;
          end
        end
        S_ISSUE: begin
          priority if (valid[pos]) begin
            state <= S_EVAL;
          end else if (at_end) begin
            state <= end_state;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_EVAL: begin
          if (put_req) begin
            if (can_put) begin
              valid[pos] <= 1'b0;
              if (is_check) begin
                failure_count <= count_inc;
                priority if (count_inc > cfg.max_timeouts) begin
                  state <= S_BROKEN;
                end else if (at_end) begin
                  state <= S_FINISH;
                end else begin
                  pos   <= pos + 1'b1;
                  state <= S_ISSUE;
                end
              end else begin
                if (!failed) begin
                  failure_count <= '0;
                  last_success  <= now;
                end
                state <= S_FINISH;
              end
            end
          end else if (at_end) begin
            state <= end_state;
          end else begin
            pos   <= pos + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_BROKEN: begin
          if (can_put) begin
            if (at_end) begin
              state <= S_FINISH;
            end else begin
              pos   <= pos + 1'b1;
              state <= S_ISSUE;
            end
          end
        end
        S_MISS: begin
          if (can_put) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (emit_ready) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/keepalive_supervisor.sv =====
// ----------------------------------------------------------------------------
// keepalive_supervisor: keepalive request supervisor
// A beat tick may search its table for a free slot; a check tick walks all
// 2*TABLE_DEPTH entries of the entry memory and a response walks them until
// its tag matches, reading and then evaluating each occupied entry, with a
// step for a broken report or a miss and for acceptance and the final result;
// results that stall hold the walk.
// One item at a time; the next is taken while the last result still waits in
// the output register.
// Reset (synchronous): tables empty, counters and success time zero, registers
// at their defaults.
// ----------------------------------------------------------------------------
module keepalive_supervisor #(
  parameter int TABLE_DEPTH = ka_pkg::TABLE_DEPTH_DEF,
  parameter int TAG_BITS    = ka_pkg::TAG_BITS_DEF,
  parameter int TIME_BITS   = ka_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_write_en,
  input  logic [ka_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [ka_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // Request input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata: now_ms, last_active_ms, response_tag, response_failed, zero pad
  input  logic [((2*TIME_BITS+ka_pkg::RTAG_BITS+1+7)/8)*8-1:0] s_tdata,
  // s_tuser: mode
  input  logic [ka_pkg::MODE_BITS-1:0]         s_tuser,
  // Result output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata: event_tag
  output logic [ka_pkg::EV_TAG_BITS-1:0]       m_tdata,
  // m_tuser: event_res
  output logic [ka_pkg::EV_BITS-1:0]           m_tuser,
  output logic                                 m_tlast
);

  localparam int NUM_ENTRIES = 2 * TABLE_DEPTH;
  localparam int AW          = $clog2(NUM_ENTRIES);
  localparam int ENTRY_BITS  = TIME_BITS + TAG_BITS;
  localparam int RTAG_LO     = 2 * TIME_BITS;
  localparam int FAIL_BIT    = RTAG_LO + ka_pkg::RTAG_BITS;

  ka_pkg::cfg_t       cfg;
  ka_pkg::emit_t      emit;
  logic               emit_ready;
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [ENTRY_BITS-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [ENTRY_BITS-1:0] ram_rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_enable      <= ka_pkg::SEND_ENABLE_RST;
      cfg.idle_interval_ms <= ka_pkg::IDLE_RST;
      cfg.long_interval_ms <= ka_pkg::LONG_RST;
      cfg.timeout_ms       <= ka_pkg::TIMEOUT_RST;
      cfg.max_timeouts     <= ka_pkg::MAX_TIMEOUT_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ka_pkg::CFG_SEND_ENABLE:  cfg.send_enable      <= cfg_data[0];
        ka_pkg::CFG_IDLE_MS:      cfg.idle_interval_ms <= cfg_data;
        ka_pkg::CFG_LONG_MS:      cfg.long_interval_ms <= cfg_data;
        ka_pkg::CFG_TIMEOUT_MS:   cfg.timeout_ms       <= cfg_data;
        ka_pkg::CFG_MAX_TIMEOUTS: cfg.max_timeouts     <= cfg_data[ka_pkg::COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request table entries: tag and send time, short table below long table.
  ka_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (NUM_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer.
  ka_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser),
    .in_now      (s_tdata[TIME_BITS-1:0]),
    .in_active   (s_tdata[RTAG_LO-1:TIME_BITS]),
    .in_rtag     (s_tdata[FAIL_BIT-1:RTAG_LO]),
    .in_failed   (s_tdata[FAIL_BIT]),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .emit        (emit),
    .emit_ready  (emit_ready)
  );

  // Output register.
  ka_outreg u_outreg (
    .clk        (clk),
    .rst        (rst),
    .emit       (emit),
    .emit_ready (emit_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== rtl/core/ka_checker.sv =====
// ----------------------------------------------------------------------------
// ka_checker: port-level checks of the keepalive supervisor
// Watches the stream ports and checks result framing and item sequencing.
// ----------------------------------------------------------------------------
module ka_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ka_pkg::EV_TAG_BITS-1:0]  m_tdata,
  input logic [ka_pkg::EV_BITS-1:0]      m_tuser,
  input logic                            m_tlast
);

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                               && $stable(m_tlast))
    else $error("result changed while stalled");

  // Only defined event codes leave the block.
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ka_pkg::EV_UNMATCHED))
    else $error("undefined event code");

  // The empty result stands alone and carries no tag.
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ka_pkg::EV_NONE) |-> m_tlast && (m_tdata == '0))
    else $error("malformed empty result");

  // Sends, drops and response outcomes are the only result of their request.
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == ka_pkg::EV_SHORT_SENT) || (m_tuser == ka_pkg::EV_LONG_SENT)
                 || (m_tuser == ka_pkg::EV_DROPPED) || (m_tuser == ka_pkg::EV_FAILED)
                 || (m_tuser == ka_pkg::EV_SUCCESS) || (m_tuser == ka_pkg::EV_UNMATCHED))
    |-> m_tlast)
    else $error("single-result event not marked last");

  // An accepted request closes the input in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

endmodule

bind keepalive_supervisor ka_checker u_ka_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== dv/keepalive_supervisor_tb.sv =====
// ----------------------------------------------------------------------------
// keepalive_supervisor_tb: self-checking bench for the keepalive supervisor
// Requests are queued by a stimulus process and sent by a clocked driver that
// works in bursts with random gaps. When a request is accepted, a behavioural
// predictor updates its own copy of the request tables and counters and
// queues the events it expects. A clocked monitor, stalling on its own
// pattern, compares each event in turn. The run covers a directed opening and
// random traffic under several register settings.
// ----------------------------------------------------------------------------
module keepalive_supervisor_tb;

  localparam int DEPTH  = ka_pkg::TABLE_DEPTH_DEF;
  localparam int TIME_W = ka_pkg::TIME_BITS_DEF;
  localparam int MODE_W = ka_pkg::MODE_BITS;
  localparam int RTAG_W = ka_pkg::RTAG_BITS;
  localparam int TDATA_W = ((2*TIME_W+RTAG_W+1+7)/8)*8;
  localparam int HOLD_CYCLES = 4*DEPTH + 40;
  localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] active;
    logic [RTAG_W-1:0] rtag;
    logic              failed;
  } req_t;

  typedef struct {
    ka_pkg::event_t                 code;
    logic [ka_pkg::EV_TAG_BITS-1:0] tag;
    logic                           last;
  } ev_rec_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write_en = 1'b0;
  logic [ka_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [ka_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [TDATA_W-1:0]                s_tdata = '0;
  logic [MODE_W-1:0]                 s_tuser = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [ka_pkg::EV_TAG_BITS-1:0]    m_tdata;
  logic [ka_pkg::EV_BITS-1:0]        m_tuser;
  logic                              m_tlast;

  // Predictor state: index 0 is the short table, index 1 the long one.
  logic                 tab_valid [2][DEPTH];
  logic [15:0]          tab_tag   [2][DEPTH];
  logic [TIME_W-1:0]    tab_sent  [2][DEPTH];
  logic [15:0]          fail_cnt = '0;
  logic [TIME_W-1:0]    success_ms = '0;
  logic [15:0]          tag_ctr = '0;
  ka_pkg::cfg_t         sup_cfg = '{ka_pkg::SEND_ENABLE_RST, ka_pkg::IDLE_RST,
                                    ka_pkg::LONG_RST, ka_pkg::TIMEOUT_RST,
                                    ka_pkg::MAX_TIMEOUT_RST};

  req_t      pending_reqs[$];
  ev_rec_t   expected_events[$];
  ev_rec_t   item_events[$];
  req_t      tx_item;
  ev_rec_t   want;
  int        pushed_cnt = 0;
  int        accepted_cnt = 0;
  int        mismatch_cnt = 0;
  int        tx_burst = 1;
  int        tx_gap = 0;
  logic [15:0] rx_pat = 16'hB3C5;
  logic [7:0]  rx_cycle = '0;
  logic [TIME_W-1:0] clock_ms = '0;

  keepalive_supervisor uut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < 2; k++)
      for (int i = 0; i < DEPTH; i++)
        tab_valid[k][i] = 1'b0;
  end

  // A time is stale when it lies in the past by more than the limit; a time
  // in the future never is.
  function automatic bit is_stale(logic [TIME_W-1:0] now, logic [TIME_W-1:0] stamp,
                                  logic [63:0] limit);
    return (now >= stamp) && (64'(now - stamp) > limit);
  endfunction

  function automatic void add_event(ka_pkg::event_t code, logic [15:0] tag);
    ev_rec_t e;
    e.code = code;
    e.tag  = tag;
    e.last = 1'b0;
    item_events.push_back(e);
  endfunction

  // Place a request in the lowest free slot, or report the table as full.
  function automatic void open_request(int k, logic [TIME_W-1:0] now,
                                       ka_pkg::event_t code);
    int slot;
    slot = -1;
    for (int i = DEPTH - 1; i >= 0; i--)
      if (!tab_valid[k][i]) slot = i;
    if (slot < 0) begin
      add_event(ka_pkg::EV_DROPPED, tag_ctr);
    end else begin
      tab_valid[k][slot] = 1'b1;
      tab_tag[k][slot]   = tag_ctr;
      tab_sent[k][slot]  = now;
      add_event(code, tag_ctr);
      tag_ctr = tag_ctr + 16'd1;
    end
  endfunction

  // Work out the events that one accepted request causes.
  function automatic void supervise_step(req_t r);
    logic [63:0] lim;
    int hit_k;
    int hit_i;
    item_events.delete();
    hit_k = -1;
    hit_i = 0;
    case (r.mode)
      ka_pkg::MODE_BEAT: begin
        if (sup_cfg.send_enable) begin
          lim = (sup_cfg.long_interval_ms != '0) ? 64'(sup_cfg.long_interval_ms)
                                                  : 64'(ka_pkg::LONG_DEFAULT_MS);
          if (is_stale(r.now, r.active, 64'(sup_cfg.idle_interval_ms)))
            open_request(0, r.now, ka_pkg::EV_SHORT_SENT);
          else if (is_stale(r.now, success_ms, lim))
            open_request(1, r.now, ka_pkg::EV_LONG_SENT);
        end
      end
      ka_pkg::MODE_CHECK: begin
        for (int k = 0; k < 2; k++) begin
          lim = (k == 0) ? 64'(sup_cfg.timeout_ms)
                         : 64'(sup_cfg.timeout_ms) * ka_pkg::LONG_TIMEOUT_FACTOR;
          for (int i = 0; i < DEPTH; i++) begin
            if (tab_valid[k][i] && is_stale(r.now, tab_sent[k][i], lim)) begin
              tab_valid[k][i] = 1'b0;
              add_event(ka_pkg::EV_TIMEOUT, tab_tag[k][i]);
              if (fail_cnt != 16'hFFFF) fail_cnt = fail_cnt + 16'd1;
              if (fail_cnt > sup_cfg.max_timeouts)
                add_event(ka_pkg::EV_BROKEN, tab_tag[k][i]);
            end
          end
        end
      end
      ka_pkg::MODE_RESPONSE: begin
        for (int k = 0; k < 2; k++)
          for (int i = 0; i < DEPTH; i++)
            if (hit_k < 0 && tab_valid[k][i] && tab_tag[k][i] == r.rtag) begin
              hit_k = k;
              hit_i = i;
            end
        if (hit_k < 0) begin
          add_event(ka_pkg::EV_UNMATCHED, r.rtag);
        end else begin
          tab_valid[hit_k][hit_i] = 1'b0;
          if (r.failed) begin
            add_event(ka_pkg::EV_FAILED, r.rtag);
          end else begin
            fail_cnt   = '0;
            success_ms = r.now;
            add_event(ka_pkg::EV_SUCCESS, r.rtag);
          end
        end
      end
      default: ;
    endcase
    if (item_events.size() == 0) add_event(ka_pkg::EV_NONE, 16'd0);
    item_events[item_events.size()-1].last = 1'b1;
    foreach (item_events[j]) expected_events.push_back(item_events[j]);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_burst <= $urandom_range(1, 8);
      tx_gap   <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        supervise_step(tx_item);
        accepted_cnt = accepted_cnt + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          tx_item = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= tx_item.mode;
          s_tdata  <= {7'd0, tx_item.failed, tx_item.rtag, tx_item.active, tx_item.now};
          if (tx_burst <= 1) begin
            tx_burst <= $urandom_range(1, 8);
            tx_gap   <= ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20)
                                                    : $urandom_range(0, 3);
          end else begin
            tx_burst <= tx_burst - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating stall pattern, renewed whenever the cycle counter wraps
  // and now and then replaced by a stretch of constant readiness.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_cycle <= '0;
    end else begin
      rx_cycle <= rx_cycle + 8'd1;
      m_tready <= rx_pat[0];
      if (rx_cycle == 8'hFF)
        rx_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1111);
      else
        rx_pat <= {rx_pat[0], rx_pat[15:1]};
    end
  end

  // Event checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10)
          $display("unexpected event: code %0d tag %h last %b", m_tuser, m_tdata, m_tlast);
      end else begin
        want = expected_events.pop_front();
        if (m_tuser !== want.code || m_tdata !== want.tag || m_tlast !== want.last) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("event mismatch: expected code %0d tag %h last %b, got %0d %h %b",
                     want.code, want.tag, want.last, m_tuser, m_tdata, m_tlast);
        end
      end
    end
  end

  task automatic push_req(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] now,
                          logic [TIME_W-1:0] active, logic [15:0] rtag, logic failed);
    req_t r;
    r.mode   = mode;
    r.now    = now;
    r.active = active;
    r.rtag   = rtag;
    r.failed = failed;
    pending_reqs.push_back(r);
    pushed_cnt = pushed_cnt + 1;
  endtask

  task automatic settle();
    while (accepted_cnt != pushed_cnt) @(posedge clk);
  endtask

  // Wait until the block has nothing left to report, then let it fall idle.
  task automatic drain();
    settle();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ka_pkg::cfg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      ka_pkg::CFG_SEND_ENABLE:  sup_cfg.send_enable      = val[0];
      ka_pkg::CFG_IDLE_MS:      sup_cfg.idle_interval_ms = val;
      ka_pkg::CFG_LONG_MS:      sup_cfg.long_interval_ms = val;
      ka_pkg::CFG_TIMEOUT_MS:   sup_cfg.timeout_ms       = val;
      ka_pkg::CFG_MAX_TIMEOUTS: sup_cfg.max_timeouts     = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [TIME_W-1:0] rand_upto(logic [63:0] span);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return TIME_W'(raw % (span + 64'd1));
  endfunction

  // A handful of requests built from the current table contents: mostly
  // beats, checks and answers to requests still outstanding, plus some noise.
  task automatic random_batch(logic [63:0] span);
    int n;
    int pick;
    int sel;
    int open_k[$];
    int open_i[$];
    req_t r;
    settle();
    for (int k = 0; k < 2; k++)
      for (int i = 0; i < DEPTH; i++)
        if (tab_valid[k][i]) begin
          open_k.push_back(k);
          open_i.push_back(i);
        end
    n = $urandom_range(1, 6);
    for (int j = 0; j < n; j++) begin
      pick     = $urandom_range(0, 99);
      r.active = TIME_W'({$urandom, $urandom});
      r.rtag   = 16'($urandom);
      r.failed = 1'($urandom);
      if (pick < 40) begin
        clock_ms = clock_ms + rand_upto(span);
        r.mode   = ka_pkg::MODE_BEAT;
        r.now    = clock_ms;
        if ($urandom_range(0, 9) != 0) r.active = clock_ms - rand_upto(2 * span);
      end else if (pick < 60) begin
        clock_ms = clock_ms + rand_upto(3 * span);
        r.mode   = ka_pkg::MODE_CHECK;
        r.now    = ($urandom_range(0, 9) == 0) ? TIME_W'({$urandom, $urandom}) : clock_ms;
      end else if (pick < 94) begin
        clock_ms = clock_ms + rand_upto(span / 4);
        r.mode   = ka_pkg::MODE_RESPONSE;
        r.now    = clock_ms;
        r.failed = ($urandom_range(0, 3) == 0);
        if (open_k.size() != 0 && pick < 88) begin
          sel    = $urandom_range(0, open_k.size() - 1);
          r.rtag = tab_tag[open_k[sel]][open_i[sel]];
        end
      end else begin
        r.mode = MODE_UNDEFINED;
        r.now  = TIME_W'({$urandom, $urandom});
      end
      push_req(r.mode, r.now, r.active, r.rtag, r.failed);
    end
  endtask

  task automatic run_phase(logic en, logic [31:0] idle, logic [31:0] lng, logic [31:0] tmo,
                           logic [15:0] max_tmo, logic [63:0] span, int count);
    int target;
    drain();
    write_reg(ka_pkg::CFG_SEND_ENABLE, {31'd0, en});
    write_reg(ka_pkg::CFG_IDLE_MS, idle);
    write_reg(ka_pkg::CFG_LONG_MS, lng);
    write_reg(ka_pkg::CFG_TIMEOUT_MS, tmo);
    write_reg(ka_pkg::CFG_MAX_TIMEOUTS, {16'd0, max_tmo});
    target = pushed_cnt + count;
    while (pushed_cnt < target) random_batch(span);
  endtask

  // Run limit.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening under the reset register values.
    push_req(MODE_UNDEFINED, '1, '1, 16'hFFFF, 1'b1);
    push_req(ka_pkg::MODE_BEAT, 48'd0, 48'd0, 16'd0, 1'b0);
    push_req(ka_pkg::MODE_BEAT, 48'd40000, 48'd0, 16'd0, 1'b0);
    push_req(ka_pkg::MODE_BEAT, 48'd40000, 48'd40000, 16'd0, 1'b0);
    push_req(ka_pkg::MODE_BEAT, 48'd200000, 48'd200000, 16'd0, 1'b0);
    push_req(ka_pkg::MODE_RESPONSE, 48'd200001, 48'd0, 16'd0, 1'b0);
    push_req(ka_pkg::MODE_RESPONSE, 48'd200002, 48'd0, 16'd1, 1'b1);
    push_req(ka_pkg::MODE_RESPONSE, 48'd200003, 48'd0, 16'd1, 1'b0);
    push_req(ka_pkg::MODE_RESPONSE, 48'd200004, 48'd0, 16'hFFFF, 1'b0);
    // Fill the short table and overflow it by one.
    for (int i = 0; i < DEPTH + 1; i++)
      push_req(ka_pkg::MODE_BEAT, 48'd300000, 48'd0, 16'd0, 1'b0);
    // Time them all out; the count passes the limit part way through.
    push_req(ka_pkg::MODE_CHECK, 48'd330001, 48'd0, 16'd0, 1'b0);
    // Last activity in the future: never idle.
    push_req(ka_pkg::MODE_BEAT, 48'd5, '1, 16'd0, 1'b0);
    push_req(ka_pkg::MODE_BEAT, '1, 48'd0, 16'd0, 1'b0);
    push_req(ka_pkg::MODE_RESPONSE, '1, 48'd0, 16'd10, 1'b1);
    push_req(ka_pkg::MODE_BEAT, '1, 48'd0, 16'd0, 1'b0);
    // A check earlier than the send time removes nothing.
    push_req(ka_pkg::MODE_CHECK, 48'd1000, 48'd0, 16'd0, 1'b0);

    clock_ms = 48'd400000;
    run_phase(1'b1, 32'd50, 32'd200, 32'd100, 16'd2, 64'd60, 38);
    run_phase(1'b1, 32'd0, 32'd0, 32'd0, 16'd0, 64'd80000, 38);
    run_phase(1'b0, 32'd20, 32'd100, 32'd40, 16'hFFFF, 64'd30, 38);
    if (clock_ms < 48'h4000_0000_0000) clock_ms = 48'h4000_0000_0000;
    run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1,
              64'h2_0000_0000, 38);
    run_phase(1'b1, 32'd30, 32'd1, 32'd60, 16'd5, 64'd40, 38);

    drain();
    mismatch_cnt = mismatch_cnt + expected_events.size();
    if (mismatch_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
